// ===== rtl/btc_pkg.sv =====
// Shared types, widths and codes for the beacon tone classifier.
package btc_pkg;

   // Field and register widths.
   localparam int PERIOD_W = 32;
   localparam int RATE_W   = 27;
   localparam int TOL_W    = 10;
   localparam int CTR_W    = 15;
   localparam int CLS_W    = 3;
   localparam int CSR_W    = 27;
   localparam int CSR_IDX_W = 3;

   // The quotient is never wider than the dividend.
   localparam int FREQ_W   = RATE_W;
   localparam int STEP_W   = $clog2(RATE_W);
   localparam int BAND_W   = 3;
   localparam int NUM_BANDS = 5;

   // Reset values of the configuration registers.
   localparam logic [RATE_W-1:0] TICK_RATE_RST  = RATE_W'(10000000);
   localparam logic [TOL_W-1:0]  TOLERANCE_RST  = TOL_W'(25);
   localparam logic [CTR_W-1:0]  FREQ_BLUE_RST  = CTR_W'(1427);
   localparam logic [CTR_W-1:0]  FREQ_LEFT_RST  = CTR_W'(2000);
   localparam logic [CTR_W-1:0]  FREQ_RIGHT_RST = CTR_W'(909);
   localparam logic [CTR_W-1:0]  FREQ_GREEN_RST = CTR_W'(3333);
   localparam logic [CTR_W-1:0]  FREQ_PLAIN_RST = CTR_W'(1427);

   // Beacon classes.
   localparam logic [CLS_W-1:0] CLS_NONE  = CLS_W'(0);
   localparam logic [CLS_W-1:0] CLS_BLUE  = CLS_W'(1);
   localparam logic [CLS_W-1:0] CLS_LEFT  = CLS_W'(2);
   localparam logic [CLS_W-1:0] CLS_RIGHT = CLS_W'(3);
   localparam logic [CLS_W-1:0] CLS_GREEN = CLS_W'(4);
   localparam logic [CLS_W-1:0] CLS_PLAIN = CLS_W'(5);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TICK_RATE  = 3'd0,
      REG_TOLERANCE  = 3'd1,
      REG_FREQ_BLUE  = 3'd2,
      REG_FREQ_LEFT  = 3'd3,
      REG_FREQ_RIGHT = 3'd4,
      REG_FREQ_GREEN = 3'd5,
      REG_FREQ_PLAIN = 3'd6
   } reg_index_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CLASSIFY,
      ST_RESPOND
   } state_type;

   // Channel payloads.
   typedef struct packed {
      logic [PERIOD_W-1:0] period_ticks;
   } req_payload_type;

   typedef struct packed {
      logic [CLS_W-1:0] beacon_class;
      logic             dispenser_seen;
      logic             side_found;
      logic             side_green;
   } rsp_payload_type;

endpackage

// ===== rtl/btc_req_if.sv =====
// Valid/ready channel that carries one period measurement word.
interface btc_req_if;
   import btc_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/btc_rsp_if.sv =====
// Valid/ready channel that carries one classification result word.
interface btc_rsp_if;
   import btc_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/beacon_tone_classifier_sequence_match_top.sv =====
// Beacon tone classifier: bit-serial frequency divider, band search and side match.
// Steps: accept the word, one-bit-per-cycle restoring division, band search (one band
// per cycle), then load the result into the output register.
// The block takes no new word until the result of the last one has been loaded.
// A new word is accepted while the previous result still waits in the output register.
// Synchronous active-high reset restores register defaults and empties the history.
module beacon_tone_classifier_sequence_match_top (
   input  logic                           clock,
   input  logic                           reset,
   btc_req_if.sink                        req_if,
   btc_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [btc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [btc_pkg::CSR_W-1:0]      csr_wdata
);
   import btc_pkg::*;

   // Configuration registers.
   logic [RATE_W-1:0] tick_rate_ff;
   logic [TOL_W-1:0]  tolerance_ff;
   logic [CTR_W-1:0]  freq_blue_ff, freq_left_ff, freq_right_ff;
   logic [CTR_W-1:0]  freq_green_ff, freq_plain_ff;

   // Sequencer and datapath registers.
   state_type         state_ff, state_in;
   logic [FREQ_W-1:0] quo_ff, quo_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W-1:0] divisor_ff;
   logic              zero_div_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BAND_W-1:0] band_ff, band_in;
   logic [CLS_W-1:0]  cls_ff, cls_in;

   // The two latest pushed classes, older in entry 0, and the fill count.
   // Together with the class being pushed they form the three-entry history.
   logic [CLS_W-1:0]  hist_ff [2];
   logic [1:0]        fill_ff;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff;

   // Control from the output decoder.
   logic              accept;
   logic              div_last;
   logic              band_hit;
   logic              band_last;
   logic              rsp_load;

   // Datapath intermediates.
   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W+1:0] diff;
   logic                trial_ge;
   logic [FREQ_W-1:0]   freq;
   logic [CTR_W-1:0]    centre;
   logic [FREQ_W:0]     lo_sum;
   logic [CTR_W:0]      hi_end;
   logic                lo_ok, hi_ok;
   logic [CLS_W-1:0]    h0, h1, h2;
   logic                ring_full;
   logic                green_match, blue_match;
   rsp_payload_type     rsp_next;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff  <= TICK_RATE_RST;
         tolerance_ff  <= TOLERANCE_RST;
         freq_blue_ff  <= FREQ_BLUE_RST;
         freq_left_ff  <= FREQ_LEFT_RST;
         freq_right_ff <= FREQ_RIGHT_RST;
         freq_green_ff <= FREQ_GREEN_RST;
         freq_plain_ff <= FREQ_PLAIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TICK_RATE:  tick_rate_ff  <= csr_wdata[RATE_W-1:0];
            REG_TOLERANCE:  tolerance_ff  <= csr_wdata[TOL_W-1:0];
            REG_FREQ_BLUE:  freq_blue_ff  <= csr_wdata[CTR_W-1:0];
            REG_FREQ_LEFT:  freq_left_ff  <= csr_wdata[CTR_W-1:0];
            REG_FREQ_RIGHT: freq_right_ff <= csr_wdata[CTR_W-1:0];
            REG_FREQ_GREEN: freq_green_ff <= csr_wdata[CTR_W-1:0];
            REG_FREQ_PLAIN: freq_plain_ff <= csr_wdata[CTR_W-1:0];
            default: ;
         endcase
      end
   end

   // One restoring division step: bring down the next dividend bit and try a subtract.
   assign trial    = {rem_ff, quo_ff[FREQ_W-1]};
   assign diff     = {1'b0, trial} - {2'b00, divisor_ff};
   assign trial_ge = !diff[PERIOD_W+1];

   // A zero period gives a zero frequency.
   assign freq = zero_div_ff ? '0 : quo_ff;

   // Centre of the band under test, in search order.
   always_comb begin
      unique case (band_ff)
         3'd0:    centre = freq_blue_ff;
         3'd1:    centre = freq_left_ff;
         3'd2:    centre = freq_right_ff;
         3'd3:    centre = freq_green_ff;
         3'd4:    centre = freq_plain_ff;
         default: centre = '0;
      endcase
   end

   // Band test: freq + tol >= centre covers a low end below zero without signs.
   assign lo_sum = {1'b0, freq} + (FREQ_W+1)'(tolerance_ff);
   assign lo_ok  = lo_sum >= (FREQ_W+1)'(centre);
   assign hi_end = {1'b0, centre} + (CTR_W+1)'(tolerance_ff);
   assign hi_ok  = freq <= FREQ_W'(hi_end);
   assign band_hit  = lo_ok && hi_ok;
   assign band_last = (band_ff == BAND_W'(NUM_BANDS - 1));
   assign div_last  = (step_ff == STEP_W'(RATE_W - 1));

   // History as it stands after this class is pushed, oldest first.
   assign h0 = hist_ff[0];
   assign h1 = hist_ff[1];
   assign h2 = cls_ff;
   assign ring_full = (fill_ff >= 2'd2);

   assign green_match = (h0 == CLS_LEFT  && h1 == CLS_RIGHT && h2 == CLS_GREEN) ||
                        (h0 == CLS_RIGHT && h1 == CLS_GREEN && h2 == CLS_LEFT)  ||
                        (h0 == CLS_GREEN && h1 == CLS_LEFT  && h2 == CLS_RIGHT);
   assign blue_match  = (h0 == CLS_RIGHT && h1 == CLS_LEFT  && h2 == CLS_BLUE)  ||
                        (h0 == CLS_LEFT  && h1 == CLS_BLUE  && h2 == CLS_RIGHT) ||
                        (h0 == CLS_BLUE  && h1 == CLS_RIGHT && h2 == CLS_LEFT);

   // Result word assembled from the final class.
   always_comb begin
      rsp_next.beacon_class   = cls_ff;
      rsp_next.dispenser_seen = (cls_ff == CLS_GREEN) || (cls_ff == CLS_BLUE);
      rsp_next.side_found     = (cls_ff != CLS_NONE) && ring_full &&
                                (green_match || blue_match);
      rsp_next.side_green     = (cls_ff != CLS_NONE) && ring_full && green_match;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_last) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            if (band_hit || band_last) state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_if.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_if.ready = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE:     req_if.ready = 1'b1;
         ST_DIVIDE:   ;
         ST_CLASSIFY: ;
         ST_RESPOND:  rsp_load = !rsp_valid_ff || rsp_if.ready;
         default:     ;
      endcase
   end

   assign accept = req_if.valid && req_if.ready;

   // Datapath next values.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      band_in = band_ff;
      cls_in  = cls_ff;
      if (accept) begin
         quo_in  = tick_rate_ff;
         rem_in  = '0;
         step_in = '0;
         band_in = '0;
      end else if (state_ff == ST_DIVIDE) begin
         quo_in  = {quo_ff[FREQ_W-2:0], trial_ge};
         rem_in  = trial_ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         step_in = step_ff + STEP_W'(1);
      end else if (state_ff == ST_CLASSIFY) begin
         band_in = band_ff + BAND_W'(1);
         if (band_hit) begin
            cls_in = band_ff + BAND_W'(1);
         end else if (band_last) begin
            cls_in = CLS_NONE;
         end
      end
   end

   // Output valid: set on load, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load && cls_ff != CLS_NONE && fill_ff != 2'd3) begin
            fill_ff <= fill_ff + 2'd1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      band_ff <= band_in;
      cls_ff  <= cls_in;
      if (accept) begin
         divisor_ff  <= req_if.data.period_ticks;
         zero_div_ff <= (req_if.data.period_ticks == '0);
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
         if (cls_ff != CLS_NONE) begin
            hist_ff[0] <= hist_ff[1];
            hist_ff[1] <= cls_ff;
         end
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule

// ===== rtl/btc_checker.sv =====
// Port-level checks for the beacon tone classifier, bound to its top level.
module btc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [btc_pkg::CLS_W-1:0]    beacon_class,
   input logic                         dispenser_seen,
   input logic                         side_found,
   input logic                         side_green
);
   import btc_pkg::*;

   // A result word waiting to be taken does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(beacon_class) && $stable(side_found) &&
                                  $stable(side_green) && $stable(dispenser_seen))
      else $error("result word changed while stalled");

   // The block works on one word at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new word accepted right after another");

   // A side match needs a pushed class.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && side_found |-> beacon_class != CLS_NONE)
      else $error("side found without a class");

   // Green side is only reported together with a match.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && side_green |-> side_found)
      else $error("green side without a match");

   // Dispenser flag follows the class.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> dispenser_seen ==
                    (beacon_class == CLS_GREEN || beacon_class == CLS_BLUE))
      else $error("dispenser flag does not match the class");

endmodule

bind beacon_tone_classifier_sequence_match_top btc_checker u_btc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .beacon_class   (rsp_if.data.beacon_class),
   .dispenser_seen (rsp_if.data.dispenser_seen),
   .side_found     (rsp_if.data.side_found),
   .side_green     (rsp_if.data.side_green)
);

// ===== test/tb.sv =====
// Self-checking testbench for the beacon tone classifier with side-sequence match.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import btc_pkg::*;

   // Register index that decodes to nothing; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_LIMIT = 50000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;

   // One full set of band registers; centre[0] is blue, centre[4] is plain.
   typedef struct packed {
      logic [RATE_W-1:0]                   tick_rate;
      logic [TOL_W-1:0]                    tolerance;
      logic [NUM_BANDS-1:0][CTR_W-1:0]     centre;
   } band_setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   btc_req_if req_bus ();
   btc_rsp_if rsp_bus ();

   beacon_tone_classifier_sequence_match_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Predictor state: its own copy of the registers and the tone history ring.
   band_setting_type band_cfg;
   logic [CLS_W-1:0] tone_hist [3];
   int unsigned hist_wr = 0;
   bit hist_full = 1'b0;
   rsp_payload_type expected_q [$];

   int mismatch_count = 0;
   int words_sent = 0;
   int results_seen = 0;
   int side_hits = 0;
   int green_hits = 0;
   int settings_loaded = 0;

   // Idle percentages and hold-off requests for the two sides of the block.
   int req_idle_pct = 12;
   int rsp_idle_pct = 66;
   int hold_len = 0;
   int hold_seq = 0;

   function automatic band_setting_type default_setting();
      band_setting_type s;
      s.tick_rate = TICK_RATE_RST;
      s.tolerance = TOLERANCE_RST;
      s.centre[CLS_BLUE-1]  = FREQ_BLUE_RST;
      s.centre[CLS_LEFT-1]  = FREQ_LEFT_RST;
      s.centre[CLS_RIGHT-1] = FREQ_RIGHT_RST;
      s.centre[CLS_GREEN-1] = FREQ_GREEN_RST;
      s.centre[CLS_PLAIN-1] = FREQ_PLAIN_RST;
      return s;
   endfunction

   function automatic band_setting_type random_setting();
      band_setting_type s;
      s.tick_rate = RATE_W'($urandom_range(100000000, 2000000));
      s.tolerance = TOL_W'($urandom_range(1000, 50));
      for (int b = 0; b < NUM_BANDS; b++) s.centre[b] = CTR_W'($urandom_range(20000));
      return s;
   endfunction

   // Tone at a given position of the green (L,R,G) or blue (R,L,B) side sequence.
   function automatic logic [CLS_W-1:0] side_tone(bit green, int pos);
      case (pos)
         0:       return green ? CLS_LEFT : CLS_RIGHT;
         1:       return green ? CLS_RIGHT : CLS_LEFT;
         default: return green ? CLS_GREEN : CLS_BLUE;
      endcase
   endfunction

   // Bands are closed intervals compared as signed numbers, so a low end under 0 is fine.
   function automatic bit tone_band_hit(logic [PERIOD_W-1:0] freq, logic [CTR_W-1:0] centre);
      longint lo, hi, v;
      lo = longint'(centre) - longint'(band_cfg.tolerance);
      hi = longint'(centre) + longint'(band_cfg.tolerance);
      v  = longint'(freq);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic bit rotation_equal(logic [2:0][CLS_W-1:0] ordered, bit green, int start);
      for (int i = 0; i < 3; i++)
         if (ordered[i] != side_tone(green, (start + i) % 3)) return 1'b0;
      return 1'b1;
   endfunction

   // Classify one period word and advance the history ring.
   function automatic rsp_payload_type predict_beacon(logic [PERIOD_W-1:0] period);
      logic [PERIOD_W-1:0] freq;
      logic [CLS_W-1:0] tone;
      logic [2:0][CLS_W-1:0] ordered;
      rsp_payload_type r;
      freq = (period == '0) ? '0 : PERIOD_W'(band_cfg.tick_rate) / period;
      tone = CLS_NONE;
      for (int b = 0; b < NUM_BANDS; b++)
         if (tone == CLS_NONE && tone_band_hit(freq, band_cfg.centre[b]))
            tone = CLS_BLUE + CLS_W'(b);
      r = '0;
      r.beacon_class = tone;
      r.dispenser_seen = (tone == CLS_GREEN) || (tone == CLS_BLUE);
      if (tone != CLS_NONE) begin
         tone_hist[hist_wr] = tone;
         hist_wr = (hist_wr + 1) % 3;
         if (hist_wr == 0) hist_full = 1'b1;
         if (hist_full) begin
            // Oldest tone first.
            for (int i = 0; i < 3; i++) ordered[i] = tone_hist[(hist_wr + i) % 3];
            for (int s = 0; s < 3 && !r.side_found; s++) begin
               if (rotation_equal(ordered, 1'b1, s)) begin
                  r.side_found = 1'b1;
                  r.side_green = 1'b1;
               end else if (rotation_equal(ordered, 1'b0, s)) begin
                  r.side_found = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

   // Period that lands near a target frequency; zero or negative targets give a zero period.
   function automatic logic [PERIOD_W-1:0] period_for_freq(int target);
      logic [PERIOD_W-1:0] p;
      if (target <= 0) return '0;
      p = PERIOD_W'(band_cfg.tick_rate) / PERIOD_W'(target);
      return (p == '0) ? PERIOD_W'(1) : p;
   endfunction

   function automatic logic [PERIOD_W-1:0] period_near(int tone);
      int centre, tol;
      centre = int'(band_cfg.centre[tone-1]);
      tol = int'(band_cfg.tolerance);
      return period_for_freq(centre - tol + int'($urandom_range(2 * tol)));
   endfunction

   function automatic void report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
   endfunction

   function automatic void check_field(string name, logic [CLS_W-1:0] want,
                                       logic [CLS_W-1:0] got);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s expected %0d got %0d",
                                   results_seen, name, want, got));
   endfunction

   // Result checking and prediction at each accepted word on either channel.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected (class %0d)",
                                         results_seen, rsp_bus.data.beacon_class));
            end else begin
               want = expected_q.pop_front();
               check_field("beacon_class", want.beacon_class, rsp_bus.data.beacon_class);
               check_field("dispenser_seen", CLS_W'(want.dispenser_seen),
                           CLS_W'(rsp_bus.data.dispenser_seen));
               check_field("side_found", CLS_W'(want.side_found),
                           CLS_W'(rsp_bus.data.side_found));
               check_field("side_green", CLS_W'(want.side_green),
                           CLS_W'(rsp_bus.data.side_green));
               if (want.side_found) begin
                  side_hits++;
                  if (want.side_green) green_hits++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_q.push_back(predict_beacon(req_bus.data.period_ticks));
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      int stall_left;
      int seen_seq;
      stall_left = 0;
      seen_seq = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != seen_seq) begin
            seen_seq = hold_seq;
            stall_left = hold_len;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offer one period word, after a random gap, and wait until it is taken.
   task automatic send_word(logic [PERIOD_W-1:0] period);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data.period_ticks <= period;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
   endtask

   // Stop offering words and wait for every outstanding result.
   task automatic drain_results(int max_cycles);
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0 && waited < max_cycles) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write every register while the block is idle, plus one write to an unused index.
   task automatic load_settings(band_setting_type s);
      write_csr(REG_TICK_RATE, CSR_W'(s.tick_rate));
      write_csr(REG_TOLERANCE, CSR_W'(s.tolerance));
      for (int b = 0; b < NUM_BANDS; b++)
         write_csr(CSR_IDX_W'(REG_FREQ_BLUE + b), CSR_W'(s.centre[b]));
      write_csr(REG_UNUSED, CSR_W'($urandom));
      csr_we <= 1'b0;
      band_cfg = s;
      settings_loaded++;
   endtask

   // Mostly complete side sequences with random band offsets, some lone tones and noise.
   task automatic run_mix(int count);
      int sent, pick, start;
      bit green;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            green = 1'($urandom_range(1));
            start = $urandom_range(2);
            for (int i = 0; i < 3; i++) send_word(period_near(side_tone(green, (start + i) % 3)));
            sent += 3;
         end else if (pick < 85) begin
            send_word(period_near($urandom_range(NUM_BANDS, 1)));
            sent++;
         end else begin
            case ($urandom_range(4))
               0:       send_word('0);
               1:       send_word('1);
               2:       send_word(PERIOD_W'($urandom_range(64)));
               default: send_word($urandom);
            endcase
            sent++;
         end
      end
   endtask

   // Zero, all-ones and unit periods, then a short mixed run, under one setting.
   task automatic probe_setting(band_setting_type s);
      load_settings(s);
      send_word('0);
      send_word('1);
      send_word(PERIOD_W'(1));
      run_mix(12);
      drain_results(DRAIN_LIMIT);
   endtask

   // Reset values: period extremes, blue band edges, and both side sequences.
   task automatic test_directed_defaults();
      int freqs [] = '{1427, 1452, 1402, 1453, 1401, 2000, 909, 3333, 2000, 909,
                       3333, 909, 2000, 1427, 909, 2000, 0};
      send_word('0);
      send_word('1);
      send_word(PERIOD_W'(1));
      foreach (freqs[i]) send_word(period_for_freq(freqs[i]));
      drain_results(DRAIN_LIMIT);
   endtask

   // Register extremes: widest bands, unit and zero dividends, zero tolerance.
   task automatic test_register_extremes();
      band_setting_type s;
      // The left band starts below 0 Hz and the plain band is reachable.
      s.tick_rate = RATE_W'(100000000);
      s.tolerance = TOL_W'(1000);
      s.centre[CLS_BLUE-1]  = CTR_W'(20000);
      s.centre[CLS_LEFT-1]  = CTR_W'(0);
      s.centre[CLS_RIGHT-1] = CTR_W'(5000);
      s.centre[CLS_GREEN-1] = CTR_W'(10000);
      s.centre[CLS_PLAIN-1] = CTR_W'(15000);
      probe_setting(s);
      // A dividend of one gives 1 Hz for a unit period and 0 Hz otherwise.
      s.tick_rate = RATE_W'(1);
      s.tolerance = TOL_W'(0);
      s.centre[CLS_BLUE-1]  = CTR_W'(0);
      s.centre[CLS_LEFT-1]  = CTR_W'(1);
      s.centre[CLS_RIGHT-1] = CTR_W'(20000);
      s.centre[CLS_GREEN-1] = CTR_W'(20000);
      s.centre[CLS_PLAIN-1] = CTR_W'(0);
      probe_setting(s);
      // A zero dividend makes every frequency 0 Hz.
      s.tick_rate = RATE_W'(0);
      s.tolerance = TOL_W'(1000);
      s.centre[CLS_BLUE-1]  = CTR_W'(20000);
      s.centre[CLS_LEFT-1]  = CTR_W'(20000);
      s.centre[CLS_RIGHT-1] = CTR_W'(1001);
      s.centre[CLS_GREEN-1] = CTR_W'(0);
      s.centre[CLS_PLAIN-1] = CTR_W'(0);
      probe_setting(s);
      // Exact-match bands at both ends of the centre range.
      s.tick_rate = RATE_W'(100000000);
      s.tolerance = TOL_W'(0);
      s.centre[CLS_BLUE-1]  = CTR_W'(20000);
      s.centre[CLS_LEFT-1]  = CTR_W'(19999);
      s.centre[CLS_RIGHT-1] = CTR_W'(1);
      s.centre[CLS_GREEN-1] = CTR_W'(0);
      s.centre[CLS_PLAIN-1] = CTR_W'(12345);
      probe_setting(s);
   endtask

   // Long random runs through the three idle modes, at reset values and random settings.
   task automatic test_random_traffic();
      int req_pct [3] = '{12, 66, 0};
      int rsp_pct [3] = '{66, 12, 0};
      for (int m = 0; m < 3; m++) begin
         req_idle_pct = req_pct[m];
         rsp_idle_pct = rsp_pct[m];
         for (int sub = 0; sub < 2; sub++) begin
            load_settings((m == 0 && sub == 0) ? default_setting() : random_setting());
            run_mix(190);
            drain_results(DRAIN_LIMIT);
         end
      end
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_backpressure();
      hold_len = HOLD_CYCLES;
      hold_seq++;
      for (int i = 0; i < 12; i++) send_word(period_near($urandom_range(NUM_BANDS, 1)));
      drain_results(DRAIN_LIMIT);
      run_mix(9);
   endtask

   initial begin
      band_cfg = default_setting();
      for (int i = 0; i < 3; i++) tone_hist[i] = CLS_NONE;
      req_bus.valid <= 1'b0;
      req_bus.data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_register_extremes();
      test_random_traffic();
      test_backpressure();

      drain_results(DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_q.size() != 0) begin
         $display("MISMATCH: %0d expected results never arrived", expected_q.size());
         mismatch_count += expected_q.size();
      end
      $display("Covered %0d words under %0d register settings, with random gaps on both sides",
               words_sent, settings_loaded);
      $display("and a long receiver hold-off; %0d results, %0d side matches (%0d green), %0d bad.",
               results_seen, side_hits, green_hits, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[beacon_tone_classifier_sequence_match_top] OK");
      end else begin
         $display("[beacon_tone_classifier_sequence_match_top] ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #8_000_000;
      $display("Run timed out with %0d results outstanding", expected_q.size());
      $display("[beacon_tone_classifier_sequence_match_top] ERROR");
      $finish;
   end

endmodule
